/* rtl/core/satrs_pkg.sv */
package satrs_pkg;

    // Fixed widths of the ports and of the table entries.
    localparam int SUM_W     = 44;
    localparam int VALUE_W   = 32;
    localparam int DIM_W     = 7;
    localparam int QIDX_W    = 6;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    // Default sizes handed to the top level.
    localparam int MAX_ROWS_DEF      = 64;
    localparam int MAX_COLS_DEF      = 64;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_BOUNDS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_READY  = 2'd2;

    typedef logic [SUM_W-1:0] sum_t;

endpackage

/* rtl/core/summed_area_table_rect_sum_top.sv */
// Summed-area table with rectangle-sum queries. A word with kind 0 loads the next matrix
// element in row-major order; a word with kind 1 asks for the sum of an inclusive rectangle
// and always produces exactly one result word, marked by a one-cycle done strobe that the
// receiver cannot hold off, so it must take rect_sum and status in that very cycle. A load
// keeps busy high through one table read of the entry above and then one table write, so
// the next word is only taken once the write is done. A valid query keeps busy high through
// four table reads, with the last sum formed in the cycle after the last read; its result
// strobes in the cycle that busy falls, and no new word is taken while it runs.
// A query that is rejected (table not fully loaded, or a reversed or out-of-range
// rectangle) leaves busy low and strobes status with a zero sum in the next cycle. This
// sequencing is set by the single-ported table memory and the one shared 44-bit adder. The
// table is not cleared after reset; a query only returns a valid sum once a whole matrix is loaded.
// Any configuration write restarts loading at row 0, column 0. A configuration write is
// held off while start is high, so a command word and a write never share a clock edge.
module summed_area_table_rect_sum_top #(
    parameter int MAX_ROWS      = satrs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS      = satrs_pkg::MAX_COLS_DEF,
    parameter int ELEMENT_WIDTH = satrs_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Command side.
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   kind,
    input  logic signed [satrs_pkg::VALUE_W-1:0]   value,
    input  logic        [satrs_pkg::QIDX_W-1:0]    row_first,
    input  logic        [satrs_pkg::QIDX_W-1:0]    col_first,
    input  logic        [satrs_pkg::QIDX_W-1:0]    row_last,
    input  logic        [satrs_pkg::QIDX_W-1:0]    col_last,
    // Result side.
    output logic                                   done,
    output logic signed [satrs_pkg::SUM_W-1:0]     rect_sum,
    output logic        [satrs_pkg::STATUS_W-1:0]  status,
    // Configuration write channel.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [satrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [satrs_pkg::DIM_W-1:0]     cfg_data
);

    localparam int SUM_W  = satrs_pkg::SUM_W;
    localparam int DIM_W  = satrs_pkg::DIM_W;
    localparam int QIDX_W = satrs_pkg::QIDX_W;
    localparam int EW     = ELEMENT_WIDTH;

    // The table is addressed as {row, column}, with the column field rounded up to a
    // power of two so that no multiply is needed to form the address.
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_ROWS * (2 ** CW);

    // Limits of the size registers: a written value above the maximum saturates.
    localparam int ROWS_CAP_I = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam int COLS_CAP_I = (MAX_COLS > 127) ? 127 : MAX_COLS;
    localparam int ROWS_RST_I = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int COLS_RST_I = (MAX_COLS < 64) ? MAX_COLS : 64;
    localparam logic [DIM_W-1:0] ROWS_CAP = DIM_W'(ROWS_CAP_I);
    localparam logic [DIM_W-1:0] COLS_CAP = DIM_W'(COLS_CAP_I);
    localparam logic [DIM_W-1:0] ROWS_RST = DIM_W'(ROWS_RST_I);
    localparam logic [DIM_W-1:0] COLS_RST = DIM_W'(COLS_RST_I);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LD_RD = 2'd1;
    localparam logic [1:0] S_LD_WR = 2'd2;
    localparam logic [1:0] S_Q_RUN = 2'd3;

    // Control registers.
    logic [1:0]                     state_reg, state_next;
    logic [2:0]                     step_reg, step_next;
    logic [DIM_W-1:0]               rows_reg, rows_next;
    logic [DIM_W-1:0]               cols_reg, cols_next;
    logic [DIM_W-1:0]               load_row_reg, load_row_next;
    logic [DIM_W-1:0]               load_col_reg, load_col_next;
    logic                           table_ready_reg, table_ready_next;
    satrs_pkg::sum_t                rsum_reg, rsum_next;
    logic                           done_reg, done_next;
    logic [satrs_pkg::STATUS_W-1:0] status_reg, status_next;

    // Payload registers.
    satrs_pkg::sum_t   rect_sum_reg, rect_sum_next;
    satrs_pkg::sum_t   wr_sum_reg, wr_sum_next;
    satrs_pkg::sum_t   acc_reg, acc_next;
    logic [DIM_W-1:0]  cur_row_reg, cur_row_next;
    logic [DIM_W-1:0]  cur_col_reg, cur_col_next;
    logic [QIDX_W-1:0] q_rf_reg, q_rf_next;
    logic [QIDX_W-1:0] q_cf_reg, q_cf_next;
    logic [QIDX_W-1:0] q_rl_reg, q_rl_next;
    logic [QIDX_W-1:0] q_cl_reg, q_cl_next;
    logic [3:0]        term_zero_reg, term_zero_next;

    // Table memory with a registered read port.
    satrs_pkg::sum_t   table_mem [DEPTH];
    satrs_pkg::sum_t   rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [DIM_W-1:0]  addr_row;
    logic [DIM_W-1:0]  addr_col;
    logic [RW+DIM_W-1:0] addr_row_ext;
    logic [CW+DIM_W-1:0] addr_col_ext;

    // Shared adder.
    satrs_pkg::sum_t   add_a;
    satrs_pkg::sum_t   add_b;
    logic              add_sub;
    satrs_pkg::sum_t   add_out;

    // Miscellaneous decode.
    logic              accept;
    logic              cfg_fire;
    logic              load_restart;
    logic [DIM_W-1:0]  ld_row;
    logic [DIM_W-1:0]  ld_col;
    satrs_pkg::sum_t   value_ext;
    satrs_pkg::sum_t   rsum_base;
    satrs_pkg::sum_t   term_val;
    logic [1:0]        term_idx;
    logic              term_sub;
    logic              query_bad;
    logic [DIM_W-1:0]  cfg_clamped_rows;
    logic [DIM_W-1:0]  cfg_clamped_cols;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign accept    = start && !busy;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign done     = done_reg;
    assign rect_sum = rect_sum_reg;
    assign status   = status_reg;

    // Only the low ELEMENT_WIDTH bits of a load word count, as a two's complement number.
    assign value_ext = {{(SUM_W - EW){value[EW-1]}}, value[EW-1:0]};

    // A load into a finished table, or from a position the sizes no longer cover,
    // begins a new matrix at the top left corner with a cleared row sum.
    assign load_restart = table_ready_reg || (load_row_reg >= rows_reg)
                          || (load_col_reg >= cols_reg);
    assign ld_row       = load_restart ? '0 : load_row_reg;
    assign ld_col       = load_restart ? '0 : load_col_reg;
    assign rsum_base    = load_restart ? '0 : rsum_reg;

    assign query_bad = (row_first > row_last) || (col_first > col_last)
                       || ({1'b0, row_last} >= rows_reg) || ({1'b0, col_last} >= cols_reg);

    // Clamp of a size write: zero becomes one, anything above the maximum saturates.
    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            cfg_clamped_rows = DIM_W'(1);
        end
        else if (cfg_data > ROWS_CAP)
        begin
            cfg_clamped_rows = ROWS_CAP;
        end
        else
        begin
            cfg_clamped_rows = cfg_data;
        end
        priority if (cfg_data == '0)
        begin
            cfg_clamped_cols = DIM_W'(1);
        end
        else if (cfg_data > COLS_CAP)
        begin
            cfg_clamped_cols = COLS_CAP;
        end
        else
        begin
            cfg_clamped_cols = cfg_data;
        end
    end

    // A query step accumulates the word read in the previous step. The second and
    // third corners are subtracted; a corner on the zero border contributes nothing.
    assign term_idx = 2'(step_reg - 3'd1);
    assign term_val = term_zero_reg[term_idx] ? '0 : rd_data_reg;
    assign term_sub = (term_idx == 2'd1) || (term_idx == 2'd2);

    // Operand selection of the shared adder.
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                add_a   = rsum_base;
                add_b   = value_ext;
                add_sub = 1'b0;
            end
            S_LD_RD:
            begin
                add_a   = '0;
                add_b   = '0;
                add_sub = 1'b0;
            end
            S_LD_WR:
            begin
                add_a   = wr_sum_reg;
                add_b   = (cur_row_reg == '0) ? '0 : rd_data_reg;
                add_sub = 1'b0;
            end
            S_Q_RUN:
            begin
                add_a   = acc_reg;
                add_b   = term_val;
                add_sub = term_sub;
            end
        endcase
    end

    assign add_out = add_sub ? (add_a - add_b) : (add_a + add_b);

    // Table address: row and column fields, each narrowed to its address bits.
    assign addr_row_ext = {{RW{1'b0}}, addr_row};
    assign addr_col_ext = {{CW{1'b0}}, addr_col};
    assign mem_addr     = {addr_row_ext[RW-1:0], addr_col_ext[CW-1:0]};

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        rows_next        = rows_reg;
        cols_next        = cols_reg;
        load_row_next    = load_row_reg;
        load_col_next    = load_col_reg;
        table_ready_next = table_ready_reg;
        rsum_next        = rsum_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        rect_sum_next    = rect_sum_reg;
        wr_sum_next      = wr_sum_reg;
        acc_next         = acc_reg;
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        q_rf_next        = q_rf_reg;
        q_cf_next        = q_cf_reg;
        q_rl_next        = q_rl_reg;
        q_cl_next        = q_cl_reg;
        term_zero_next   = term_zero_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        addr_row         = cur_row_reg;
        addr_col         = cur_col_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    if (cfg_index == satrs_pkg::REG_ROWS_IN_USE)
                    begin
                        rows_next = cfg_clamped_rows;
                    end
                    else
                    begin
                        cols_next = cfg_clamped_cols;
                    end
                    load_row_next    = '0;
                    load_col_next    = '0;
                    rsum_next        = '0;
                    table_ready_next = 1'b0;
                end
                else if (accept && !kind)
                begin
                    // Element load: the prefix of this row is formed now, the entry
                    // above is fetched next, and the table entry is written after that.
                    wr_sum_next  = add_out;
                    cur_row_next = ld_row;
                    cur_col_next = ld_col;
                    if ({1'b0, ld_col} + 8'd1 >= {1'b0, cols_reg})
                    begin
                        load_col_next = '0;
                        rsum_next     = '0;
                        if ({1'b0, ld_row} + 8'd1 >= {1'b0, rows_reg})
                        begin
                            load_row_next    = '0;
                            table_ready_next = 1'b1;
                        end
                        else
                        begin
                            load_row_next    = ld_row + DIM_W'(1);
                            table_ready_next = 1'b0;
                        end
                    end
                    else
                    begin
                        load_col_next    = ld_col + DIM_W'(1);
                        load_row_next    = ld_row;
                        rsum_next        = add_out;
                        table_ready_next = 1'b0;
                    end
                    state_next = S_LD_RD;
                end
                else if (accept && kind)
                begin
                    priority if (!table_ready_reg)
                    begin
                        done_next     = 1'b1;
                        status_next   = satrs_pkg::ST_NOT_READY;
                        rect_sum_next = '0;
                    end
                    else if (query_bad)
                    begin
                        done_next     = 1'b1;
                        status_next   = satrs_pkg::ST_BAD_BOUNDS;
                        rect_sum_next = '0;
                    end
                    else
                    begin
                        q_rf_next      = row_first;
                        q_cf_next      = col_first;
                        q_rl_next      = row_last;
                        q_cl_next      = col_last;
                        term_zero_next = {(row_first == '0) || (col_first == '0),
                                          (col_first == '0), (row_first == '0), 1'b0};
                        acc_next       = '0;
                        step_next      = '0;
                        state_next     = S_Q_RUN;
                    end
                end
            end
            S_LD_RD:
            begin
                // Entry directly above; on the first row the read is ignored.
                mem_re     = 1'b1;
                addr_row   = cur_row_reg - DIM_W'(1);
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                mem_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_Q_RUN:
            begin
                if (!step_reg[2])
                begin
                    mem_re = 1'b1;
                    unique case (step_reg[1:0])
                        2'd0:
                        begin
                            addr_row = {1'b0, q_rl_reg};
                            addr_col = {1'b0, q_cl_reg};
                        end
                        2'd1:
                        begin
                            addr_row = {1'b0, q_rf_reg - QIDX_W'(1)};
                            addr_col = {1'b0, q_cl_reg};
                        end
                        2'd2:
                        begin
                            addr_row = {1'b0, q_rl_reg};
                            addr_col = {1'b0, q_cf_reg - QIDX_W'(1)};
                        end
                        2'd3:
                        begin
                            addr_row = {1'b0, q_rf_reg - QIDX_W'(1)};
                            addr_col = {1'b0, q_cf_reg - QIDX_W'(1)};
                        end
                    endcase
                end
                if (step_reg != '0)
                begin
                    acc_next = add_out;
                end
                if (step_reg[2])
                begin
                    done_next     = 1'b1;
                    status_next   = satrs_pkg::ST_OK;
                    rect_sum_next = add_out;
                    state_next    = S_IDLE;
                end
                step_next = step_reg + 3'd1;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            rows_reg        <= ROWS_RST;
            cols_reg        <= COLS_RST;
            load_row_reg    <= '0;
            load_col_reg    <= '0;
            table_ready_reg <= 1'b0;
            rsum_reg        <= '0;
            done_reg        <= 1'b0;
            status_reg      <= satrs_pkg::ST_OK;
            rect_sum_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            rows_reg        <= rows_next;
            cols_reg        <= cols_next;
            load_row_reg    <= load_row_next;
            load_col_reg    <= load_col_next;
            table_ready_reg <= table_ready_next;
            rsum_reg        <= rsum_next;
            done_reg        <= done_next;
            status_reg      <= status_next;
            rect_sum_reg    <= rect_sum_next;
        end
    end

    // Working payload, no reset needed.
    always_ff @(posedge clk)
    begin
        wr_sum_reg    <= wr_sum_next;
        acc_reg       <= acc_next;
        cur_row_reg   <= cur_row_next;
        cur_col_reg   <= cur_col_next;
        q_rf_reg      <= q_rf_next;
        q_cf_reg      <= q_cf_next;
        q_rl_reg      <= q_rl_next;
        q_cl_reg      <= q_cl_next;
        term_zero_reg <= term_zero_next;
    end

    // Single-ported table: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_addr] <= add_out;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_mem[mem_addr];
        end
    end

    // A result word only follows a query accept or the end of a query sequence.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (($past(state_reg) == S_Q_RUN)
                  || ($past(start) && !$past(busy) && $past(kind))))
        else $error("result strobe without a query");

    // A rejected query always carries a zero sum.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != satrs_pkg::ST_OK)) |-> (rect_sum == '0))
        else $error("rejected query with a nonzero sum");

    // A finished table leaves the load position at the top left corner.
    a_ready_pos: assert property (@(posedge clk) disable iff (!rst_n)
        table_ready_reg |-> ((load_row_reg == '0) && (load_col_reg == '0)))
        else $error("table ready with a load position in the middle");

    // The load position stays inside the matrix in use.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (load_row_reg < rows_reg) && (load_col_reg < cols_reg))
        else $error("load position outside the matrix");

endmodule

/* test/tb_summed_area_table_rect_sum_top.sv */
module tb_summed_area_table_rect_sum_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Widths taken from the package.
    localparam int SUM_W     = satrs_pkg::SUM_W;
    localparam int VALUE_W   = satrs_pkg::VALUE_W;
    localparam int DIM_W     = satrs_pkg::DIM_W;
    localparam int QIDX_W    = satrs_pkg::QIDX_W;
    localparam int STATUS_W  = satrs_pkg::STATUS_W;
    localparam int CFG_IDX_W = satrs_pkg::CFG_IDX_W;

    // The block is built with its default sizes, so the local copy of the
    // table uses the same ones.
    localparam int TAB_ROWS     = satrs_pkg::MAX_ROWS_DEF;
    localparam int TAB_COLS     = satrs_pkg::MAX_COLS_DEF;
    localparam int RANDOM_WORDS = 700;
    localparam int SETTLE_CYCLES = 8;

    // One command word as the sender presents it.
    typedef struct {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
        logic [QIDX_W-1:0]         row_first;
        logic [QIDX_W-1:0]         col_first;
        logic [QIDX_W-1:0]         row_last;
        logic [QIDX_W-1:0]         col_last;
    } sat_word_t;

    // One result word as the block should present it.
    typedef struct {
        satrs_pkg::sum_t     sum;
        logic [STATUS_W-1:0] status;
    } rect_result_t;

    // Word kinds on the command side.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        kind;
    logic signed [VALUE_W-1:0]   value;
    logic        [QIDX_W-1:0]    row_first;
    logic        [QIDX_W-1:0]    col_first;
    logic        [QIDX_W-1:0]    row_last;
    logic        [QIDX_W-1:0]    col_last;
    logic                        done;
    logic signed [SUM_W-1:0]     rect_sum;
    logic        [STATUS_W-1:0]  status;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic        [CFG_IDX_W-1:0] cfg_index;
    logic        [DIM_W-1:0]     cfg_data;

    summed_area_table_rect_sum_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .value     (value),
        .row_first (row_first),
        .col_first (col_first),
        .row_last  (row_last),
        .col_last  (col_last),
        .done      (done),
        .rect_sum  (rect_sum),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Local copy of the block's state. The table image only ever gets read
    // at entries written for the matrix that is currently complete, which
    // mirrors the block, whose table memory is not cleared after reset.
    // ------------------------------------------------------------------
    satrs_pkg::sum_t table_img [TAB_ROWS*TAB_COLS];
    int              next_row;
    int              next_col;
    satrs_pkg::sum_t row_acc;
    bit              table_full;
    int              rows_used = TAB_ROWS;
    int              cols_used = TAB_COLS;

    // Results still owed by the block, oldest first.
    rect_result_t expected_sums[$];

    int           mismatch_count = 0;
    int           words_sent = 0;
    // When set, the sender presents words back to back with no idle cycles.
    bit           steady_sender = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // A written size of zero means one; anything above the table size is
    // cut back to the table size.
    function automatic int clamp_dim(input logic [DIM_W-1:0] raw, input int limit);
        if (raw == '0)
            return 1;
        if (int'(raw) > limit)
            return limit;
        return int'(raw);
    endfunction

    function automatic void restart_matrix();
        next_row   = 0;
        next_col   = 0;
        row_acc    = '0;
        table_full = 1'b0;
    endfunction

    // Table entry with a zero border on the top row and the left column.
    function automatic satrs_pkg::sum_t corner_sum(input int r1, input int c1);
        if (r1 == 0 || c1 == 0)
            return '0;
        return table_img[(r1 - 1) * TAB_COLS + (c1 - 1)];
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [DIM_W-1:0] data);
        if (idx == satrs_pkg::REG_ROWS_IN_USE)
            rows_used = clamp_dim(data, TAB_ROWS);
        else
            cols_used = clamp_dim(data, TAB_COLS);
        restart_matrix();
    endfunction

    // Runs one accepted word through the local copy. A load updates the
    // table image and the load position; a query queues its result.
    function automatic void model_table_word(input sat_word_t w);
        int              r;
        int              c;
        int              rf;
        int              cf;
        int              rl;
        int              cl;
        satrs_pkg::sum_t elem;
        satrs_pkg::sum_t above;
        rect_result_t    res;
        if (w.kind == KIND_LOAD)
        begin
            elem = {{(SUM_W - VALUE_W){w.value[VALUE_W-1]}}, w.value};
            if (table_full)
                restart_matrix();
            r = next_row;
            c = next_col;
            if (r >= rows_used || c >= cols_used)
            begin
                restart_matrix();
                r = 0;
                c = 0;
            end
            row_acc = row_acc + elem;
            above   = (r == 0) ? satrs_pkg::sum_t'(0) : table_img[(r - 1) * TAB_COLS + c];
            table_img[r * TAB_COLS + c] = above + row_acc;
            if (c + 1 >= cols_used)
            begin
                next_col = 0;
                row_acc  = '0;
                if (r + 1 >= rows_used)
                begin
                    next_row   = 0;
                    table_full = 1'b1;
                end
                else
                    next_row = r + 1;
            end
            else
                next_col = c + 1;
        end
        else
        begin
            rf = int'(w.row_first);
            cf = int'(w.col_first);
            rl = int'(w.row_last);
            cl = int'(w.col_last);
            res.sum = '0;
            // Readiness is judged before the bounds.
            if (!table_full)
                res.status = satrs_pkg::ST_NOT_READY;
            else if (rf > rl || cf > cl || rl >= rows_used || cl >= cols_used)
                res.status = satrs_pkg::ST_BAD_BOUNDS;
            else
            begin
                res.status = satrs_pkg::ST_OK;
                res.sum = corner_sum(rl + 1, cl + 1) - corner_sum(rf, cl + 1)
                        - corner_sum(rl + 1, cf) + corner_sum(rf, cf);
            end
            expected_sums.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------
    // Word builders. Fields that a word does not use still carry random
    // bits so that every input bit moves during the run.
    // ------------------------------------------------------------------
    function automatic sat_word_t make_load(input logic signed [VALUE_W-1:0] v);
        sat_word_t w;
        w.kind      = KIND_LOAD;
        w.value     = v;
        w.row_first = QIDX_W'($urandom);
        w.col_first = QIDX_W'($urandom);
        w.row_last  = QIDX_W'($urandom);
        w.col_last  = QIDX_W'($urandom);
        return w;
    endfunction

    function automatic sat_word_t make_query(input int rf, input int cf,
                                             input int rl, input int cl);
        sat_word_t w;
        w.kind      = KIND_QUERY;
        w.value     = VALUE_W'($urandom);
        w.row_first = QIDX_W'(rf);
        w.col_first = QIDX_W'(cf);
        w.row_last  = QIDX_W'(rl);
        w.col_last  = QIDX_W'(cl);
        return w;
    endfunction

    // Matrix elements lean on the two extremes and on small values, so that
    // sums both cancel and grow toward the top of the sum range.
    function automatic logic signed [VALUE_W-1:0] pick_element();
        int sel;
        sel = $urandom_range(7, 0);
        case (sel)
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return VALUE_W'(int'($urandom_range(15, 0)) - 8);
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic sat_word_t pick_noise_query();
        return make_query($urandom_range(63, 0), $urandom_range(63, 0),
                          $urandom_range(63, 0), $urandom_range(63, 0));
    endfunction

    // Mostly rectangles that fit the current matrix, some reversed ones and
    // some with fully random corners.
    function automatic sat_word_t pick_query();
        int sel;
        int rf;
        int cf;
        int rl;
        int cl;
        sel = $urandom_range(99, 0);
        rf  = $urandom_range(rows_used - 1, 0);
        rl  = $urandom_range(rows_used - 1, rf);
        cf  = $urandom_range(cols_used - 1, 0);
        cl  = $urandom_range(cols_used - 1, cf);
        if (sel < 70)
            return make_query(rf, cf, rl, cl);
        if (sel < 85 && rf != rl)
            return make_query(rl, cf, rf, cl);
        if (sel < 85 && cf != cl)
            return make_query(rf, cl, rl, cf);
        return pick_noise_query();
    endfunction

    // Idle cycles between words: mostly none or a few, now and then a long
    // stretch.
    function automatic int pick_gap();
        int sel;
        if (steady_sender)
            return 0;
        sel = $urandom_range(99, 0);
        if (sel < 45)
            return 0;
        if (sel < 85)
            return $urandom_range(3, 1);
        if (sel < 96)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // ------------------------------------------------------------------
    // Sender side. A word is presented at a falling edge and taken at the
    // first rising edge where busy is low. If no gap follows, start simply
    // stays high and the next word replaces the fields at the next falling
    // edge.
    // ------------------------------------------------------------------
    task automatic send_word(input sat_word_t w);
        int gap;
        @(negedge clk);
        start     = 1'b1;
        kind      = w.kind;
        value     = w.value;
        row_first = w.row_first;
        col_first = w.col_first;
        row_last  = w.row_last;
        col_last  = w.col_last;
        do
            @(posedge clk);
        while (busy);
        model_table_word(w);
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic stop_sender();
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic wait_for_results();
        while (expected_sums.size() != 0)
            @(posedge clk);
    endtask

    // Register writes happen only with the block idle: every owed result
    // has come back, and a load that produces no result has had time to
    // finish its table write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DIM_W-1:0] data);
        stop_sender();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side. The block cannot be held off, so every cycle with done
    // high carries a word that must match the oldest owed result.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        rect_result_t want;
        if (rst_n && done)
        begin
            if (expected_sums.size() == 0)
                report_mismatch($sformatf("result word with no query waiting: status %0d sum %h",
                                          status, rect_sum));
            else
            begin
                want = expected_sums.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (rect_sum !== want.sum)
                    report_mismatch($sformatf("rect_sum %h, expected %h", rect_sum, want.sum));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset nothing is loaded, so every query answers "not
    // ready", even one whose rectangle is also reversed.
    task automatic test_query_before_load();
        send_word(make_query(0, 0, 0, 0));
        send_word(make_query(63, 63, 63, 63));
        send_word(make_query(63, 0, 0, 63));
    endtask

    // Sizes written as zero act as one: a 1x1 matrix is complete after a
    // single load, and the next load starts a fresh one.
    task automatic test_register_clamping();
        write_register(satrs_pkg::REG_ROWS_IN_USE, '0);
        write_register(satrs_pkg::REG_COLS_IN_USE, '0);
        send_word(make_load(32'sh7FFF_FFFF));
        send_word(make_query(0, 0, 0, 0));
        send_word(make_load(32'sh8000_0000));
        send_word(make_query(0, 0, 0, 0));
        send_word(make_query(0, 0, 1, 0));
        send_word(make_query(0, 0, 0, 1));
    endtask

    // A 2x2 matrix with extreme elements, every kind of bad rectangle, and
    // a load into the complete table that throws it away.
    task automatic test_bounds_and_reload();
        write_register(satrs_pkg::REG_ROWS_IN_USE, 7'd2);
        write_register(satrs_pkg::REG_COLS_IN_USE, 7'd2);
        send_word(make_load(32'sh8000_0000));
        send_word(make_load(32'sh7FFF_FFFF));
        send_word(make_load(-32'sd1));
        send_word(make_load(32'sd1));
        send_word(make_query(0, 0, 1, 1));
        send_word(make_query(0, 1, 1, 1));
        send_word(make_query(1, 0, 0, 1));
        send_word(make_query(0, 1, 1, 0));
        send_word(make_query(0, 0, 1, 2));
        send_word(make_query(0, 0, 2, 1));
        send_word(make_load(32'sd5));
        send_word(make_query(0, 0, 0, 0));
        send_word(make_load(32'sh8000_0000));
        send_word(make_load(32'sh8000_0000));
        send_word(make_load(32'sh8000_0000));
        send_word(make_query(0, 0, 1, 1));
    endtask

    // A register write halfway through a matrix drops what was loaded.
    task automatic test_config_restart();
        write_register(satrs_pkg::REG_ROWS_IN_USE, 7'd3);
        write_register(satrs_pkg::REG_COLS_IN_USE, 7'd2);
        send_word(make_load(pick_element()));
        send_word(make_load(pick_element()));
        write_register(satrs_pkg::REG_COLS_IN_USE, 7'd3);
        send_word(make_query(0, 0, 0, 0));
    endtask

    // Random matrices. Each phase picks new sizes, loads whole matrices with
    // random elements (an odd query mixed in while loading), asks a batch of
    // queries and sometimes starts a new matrix that it leaves unfinished.
    // The first two phases use a 64-row and a 64-column shape so that the
    // last row and column of the table are always reached; later phases
    // stay mostly small, since each load holds the block busy for a table read and a write.
    task automatic test_random_matrices();
        int               target;
        int               phase;
        int               shape;
        int               n_cells;
        int               n_passes;
        int               pass_idx;
        int               i;
        int               n_queries;
        int               k;
        logic [DIM_W-1:0] rows_raw;
        logic [DIM_W-1:0] cols_raw;
        target = words_sent + RANDOM_WORDS;
        phase  = 0;
        while (words_sent < target)
        begin
            shape = (phase < 2) ? phase : $urandom_range(9, 0);
            case (shape)
                0:
                begin
                    rows_raw = DIM_W'($urandom_range(127, 64));
                    cols_raw = DIM_W'($urandom_range(3, 0));
                end
                1:
                begin
                    rows_raw = DIM_W'($urandom_range(3, 0));
                    cols_raw = DIM_W'($urandom_range(127, 64));
                end
                default:
                begin
                    rows_raw = DIM_W'($urandom_range(8, 0));
                    cols_raw = DIM_W'($urandom_range(8, 0));
                end
            endcase
            if ($urandom_range(1, 0) == 0)
            begin
                write_register(satrs_pkg::REG_ROWS_IN_USE, rows_raw);
                write_register(satrs_pkg::REG_COLS_IN_USE, cols_raw);
            end
            else
            begin
                write_register(satrs_pkg::REG_COLS_IN_USE, cols_raw);
                write_register(satrs_pkg::REG_ROWS_IN_USE, rows_raw);
            end
            steady_sender = ($urandom_range(3, 0) == 0);
            n_cells  = rows_used * cols_used;
            n_passes = (n_cells > 32) ? 1 : $urandom_range(3, 1);
            for (pass_idx = 0; pass_idx < n_passes; pass_idx++)
            begin
                for (i = 0; i < n_cells; i++)
                begin
                    if ($urandom_range(15, 0) == 0)
                        send_word(pick_noise_query());
                    send_word(make_load(pick_element()));
                end
                n_queries = $urandom_range(10, 3);
                for (i = 0; i < n_queries; i++)
                    send_word(pick_query());
                // Now and then the sender holds back until the block has
                // answered everything it owes.
                if (phase == 0 || $urandom_range(5, 0) == 0)
                begin
                    stop_sender();
                    wait_for_results();
                end
            end
            if (n_cells > 1 && $urandom_range(2, 0) == 0)
            begin
                k = $urandom_range(n_cells - 1, 1);
                for (i = 0; i < k; i++)
                    send_word(make_load(pick_element()));
                send_word(pick_query());
            end
            phase++;
        end
        steady_sender = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int waited;
        rst_n     = 1'b0;
        start     = 1'b0;
        kind      = KIND_LOAD;
        value     = '0;
        row_first = '0;
        col_first = '0;
        row_last  = '0;
        col_last  = '0;
        cfg_valid = 1'b0;
        cfg_index = satrs_pkg::REG_ROWS_IN_USE;
        cfg_data  = '0;
        restart_matrix();
        foreach (table_img[i])
            table_img[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_query_before_load();
        test_register_clamping();
        test_bounds_and_reload();
        test_config_restart();
        test_random_matrices();

        // Drain: let every owed result come back, then wait SETTLE_CYCLES more to
        // catch any stray result word.
        stop_sender();
        for (waited = 0; waited < 2000 && expected_sums.size() != 0; waited++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (expected_sums.size() != 0)
        begin
            void'(expected_sums.pop_front());
            report_mismatch("query result never came back");
        end

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Safety net: a correct run ends long before this.
    initial
    begin
        #2_000_000;
        $display("TIMEOUT @%0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* summed_area_table_rect_sum_top.f */
rtl/core/satrs_pkg.sv
rtl/core/summed_area_table_rect_sum_top.sv
test/tb_summed_area_table_rect_sum_top.sv
